### rtl/core/vwir_pkg.sv
// vwir_pkg: shared types, widths and codes for the vertex weld / index remap core
// no dependencies; imported by every module of the core and by the checker
package vwir_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int COORD_W      = 24;
    localparam int TOL_W        = 23;
    localparam int FIELD_W      = 10;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int SQ_W         = 2 * TOL_W;
    localparam int SUM_W        = SQ_W + 2;

    localparam int IN_DATA_W    = 104;
    localparam int IN_USER_W    = 2;
    localparam int OUT_DATA_W   = 32;
    localparam int OUT_USER_W   = 3;

    localparam logic       REQ_VERTEX  = 1'b0;
    localparam logic       REQ_FACE    = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_UNLOADED = 2'd2;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_coord3;

    // travels alongside each kept-vertex read through the compare pipeline
    typedef struct packed {
        logic             vld;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_cmp_tag;

    typedef struct packed {
        logic               req_type;
        logic               new_mesh;
        t_coord3            coord;
        logic [FIELD_W-1:0] face_a;
        logic [FIELD_W-1:0] face_b;
        logic [FIELD_W-1:0] face_c;
    } t_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_VCHK,
        S_SEARCH,
        S_COMMIT,
        S_FACE_A,
        S_FACE_B,
        S_FACE_C,
        S_FACE_W,
        S_RESULT
    } t_state;

endpackage

### rtl/core/vwir_kept_mem.sv
// vwir_kept_mem: synchronous memory of kept vertex positions, one read and one write port
// depends on vwir_pkg for the coordinate type and depth
module vwir_kept_mem
    import vwir_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_coord3          i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_raddr,
    output t_coord3          o_rdata
);

    t_coord3 r_mem [MAX_VERTICES];
    t_coord3 r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/vwir_remap_mem.sv
// vwir_remap_mem: synchronous memory holding the compacted index of each original vertex
// depends on vwir_pkg for index width and depth
module vwir_remap_mem
    import vwir_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  logic [IDX_W-1:0] i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_raddr,
    output logic [IDX_W-1:0] o_rdata
);

    logic [IDX_W-1:0] r_mem [MAX_VERTICES];
    logic [IDX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/vwir_dist_cmp.sv
// vwir_dist_cmp: three-stage squared-distance compare of a candidate against one kept vertex
// depends on vwir_pkg; takes one kept vertex per cycle with its tag, kill empties the pipe
module vwir_dist_cmp
    import vwir_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_kill,
    input  logic [TOL_W-1:0] i_tol,
    input  t_coord3          i_vtx,
    input  t_coord3          i_kept,
    input  t_cmp_tag         i_tag,
    output t_cmp_tag         o_tag,
    output logic             o_match
);

    logic [SQ_W-1:0]   r_tol2;

    t_cmp_tag          r_s1_tag, r_s2_tag, r_s3_tag;
    logic              r_s1_far, r_s2_far;
    logic [TOL_W-1:0]  r_s1_dx, r_s1_dy, r_s1_dz;
    logic [SQ_W-1:0]   r_s2_qx, r_s2_qy, r_s2_qz;
    logic              r_s3_match;

    logic [DIFF_W-1:0] dx, dy, dz;
    logic [DIFF_W-1:0] tol_ext;
    logic              far;
    logic [SUM_W-1:0]  sum;

    function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                   input logic signed [COORD_W-1:0] b);
        logic signed [DIFF_W-1:0] d;
        d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    endfunction

    always_comb begin
        dx      = abs_diff(i_vtx.x, i_kept.x);
        dy      = abs_diff(i_vtx.y, i_kept.y);
        dz      = abs_diff(i_vtx.z, i_kept.z);
        tol_ext = DIFF_W'(i_tol);
        // beyond the tolerance on any axis: no match, whatever the squares sum to
        far     = (dx > tol_ext) || (dy > tol_ext) || (dz > tol_ext);
        sum     = SUM_W'(r_s2_qx) + SUM_W'(r_s2_qy) + SUM_W'(r_s2_qz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol2     <= '0;
            r_s1_tag   <= '0;
            r_s2_tag   <= '0;
            r_s3_tag   <= '0;
            r_s3_match <= 1'b0;
        end else begin
            r_tol2     <= SQ_W'(i_tol) * SQ_W'(i_tol);
            r_s1_tag   <= i_kill ? '0 : i_tag;
            r_s2_tag   <= i_kill ? '0 : r_s1_tag;
            r_s3_tag   <= i_kill ? '0 : r_s2_tag;
            r_s3_match <= !r_s2_far && (sum < SUM_W'(r_tol2));
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_far <= far;
        r_s1_dx  <= TOL_W'(dx);
        r_s1_dy  <= TOL_W'(dy);
        r_s1_dz  <= TOL_W'(dz);
        r_s2_far <= r_s1_far;
        r_s2_qx  <= SQ_W'(r_s1_dx) * SQ_W'(r_s1_dx);
        r_s2_qy  <= SQ_W'(r_s1_dy) * SQ_W'(r_s1_dy);
        r_s2_qz  <= SQ_W'(r_s1_dz) * SQ_W'(r_s1_dz);
    end

    assign o_tag   = r_s3_tag;
    assign o_match = r_s3_match;

endmodule

### rtl/core/vertex_weld_index_remap_core.sv
// Vertex weld and index remap core: welds vertices closer than weld_tolerance and maps face
// indices onto the compacted vertex list. Items are taken one at a time. For a vertex item the
// search reads the kept-vertex memory once per cycle and streams each position through a
// three-stage squared-distance compare, stopping at the first match; while nothing is kept
// yet the search is skipped. A face item makes one remap memory read per index. A vertex
// arriving on a full table skips the search and answers with status full. The result sits in
// an output register, so a new transaction is taken while the previous result waits on
// m_axis_tready.
// depends on vwir_pkg, vwir_kept_mem, vwir_remap_mem and vwir_dist_cmp
module vertex_weld_index_remap_core
    import vwir_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [TOL_W-1:0]      i_cfg_wdata,   // weld_tolerance
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // coord_x [23:0], coord_y [47:24], coord_z [71:48], face_a [81:72],
    // face_b [91:82], face_c [101:92], zero [103:102]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // req_type [0], new_mesh [1]
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // mapped_a [9:0], mapped_b [19:10], mapped_c [29:20], zero [31:30]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status [1:0], is_new [2]
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    t_state             r_state, n_state;
    logic [TOL_W-1:0]   r_tol;
    logic [CNT_W-1:0]   r_vc, n_vc;
    logic [CNT_W-1:0]   r_kc, n_kc;
    logic [CNT_W-1:0]   r_iss, n_iss;
    t_item              r_item, n_item;
    t_cmp_tag           r_rd_tag, n_rd_tag;
    logic               r_found, n_found;
    logic [IDX_W-1:0]   r_hit, n_hit;
    logic [1:0]         r_res_st, n_res_st;
    logic               r_res_new, n_res_new;
    logic [FIELD_W-1:0] r_res_ma, n_res_ma;
    logic [FIELD_W-1:0] r_res_mb, n_res_mb;
    logic [FIELD_W-1:0] r_res_mc, n_res_mc;
    logic               r_out_vld, n_out_vld;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;
    logic [OUT_USER_W-1:0] r_out_user, n_out_user;

    logic               in_acc;
    logic               kept_we, kept_re;
    logic [IDX_W-1:0]   kept_waddr, kept_raddr;
    t_coord3            kept_rdata;
    logic               remap_we, remap_re;
    logic [IDX_W-1:0]   remap_waddr, remap_wdata, remap_raddr;
    logic [IDX_W-1:0]   remap_rdata;
    logic               kill;
    t_cmp_tag           cmp_tag;
    logic               cmp_match;
    logic [IDX_W-1:0]   commit_idx;
    logic [FIELD_W-1:0] face_sel;
    logic [FIELD_W-1:0] face_prev;
    logic               prev_ok;
    logic [FIELD_W-1:0] prev_map;

    vwir_kept_mem u_kept_mem (
        .i_clk   (i_clk),
        .i_we    (kept_we),
        .i_waddr (kept_waddr),
        .i_wdata (r_item.coord),
        .i_re    (kept_re),
        .i_raddr (kept_raddr),
        .o_rdata (kept_rdata)
    );

    vwir_remap_mem u_remap_mem (
        .i_clk   (i_clk),
        .i_we    (remap_we),
        .i_waddr (remap_waddr),
        .i_wdata (remap_wdata),
        .i_re    (remap_re),
        .i_raddr (remap_raddr),
        .o_rdata (remap_rdata)
    );

    vwir_dist_cmp u_dist_cmp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_kill  (kill),
        .i_tol   (r_tol),
        .i_vtx   (r_item.coord),
        .i_kept  (kept_rdata),
        .i_tag   (r_rd_tag),
        .o_tag   (cmp_tag),
        .o_match (cmp_match)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    always_comb begin
        // index being read in this face step, and the one whose data returns now
        case (r_state)
            S_FACE_A: face_sel = r_item.face_a;
            S_FACE_B: face_sel = r_item.face_b;
            default:  face_sel = r_item.face_c;
        endcase
        case (r_state)
            S_FACE_B: face_prev = r_item.face_a;
            S_FACE_C: face_prev = r_item.face_b;
            default:  face_prev = r_item.face_c;
        endcase
        prev_ok  = 32'(face_prev) < 32'(r_vc);
        prev_map = prev_ok ? FIELD_W'(remap_rdata) : '0;
        commit_idx = r_found ? r_hit : IDX_W'(r_kc);
    end

    always_comb begin
        n_state    = r_state;
        n_vc       = r_vc;
        n_kc       = r_kc;
        n_iss      = r_iss;
        n_item     = r_item;
        n_rd_tag   = '0;
        n_found    = r_found;
        n_hit      = r_hit;
        n_res_st   = r_res_st;
        n_res_new  = r_res_new;
        n_res_ma   = r_res_ma;
        n_res_mb   = r_res_mb;
        n_res_mc   = r_res_mc;
        n_out_vld  = r_out_vld && !m_axis_tready;
        n_out_data = r_out_data;
        n_out_user = r_out_user;

        kept_we     = 1'b0;
        kept_waddr  = IDX_W'(r_kc);
        kept_re     = 1'b0;
        kept_raddr  = IDX_W'(r_iss);
        remap_we    = 1'b0;
        remap_waddr = IDX_W'(r_vc);
        remap_wdata = commit_idx;
        remap_re    = 1'b0;
        remap_raddr = IDX_W'(face_sel);
        kill        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_item.coord.x  = s_axis_tdata[23:0];
                    n_item.coord.y  = s_axis_tdata[47:24];
                    n_item.coord.z  = s_axis_tdata[71:48];
                    n_item.face_a   = s_axis_tdata[81:72];
                    n_item.face_b   = s_axis_tdata[91:82];
                    n_item.face_c   = s_axis_tdata[101:92];
                    n_item.req_type = s_axis_tuser[0];
                    n_item.new_mesh = s_axis_tuser[1];
                    if (s_axis_tuser[1]) begin
                        n_vc = '0;
                        n_kc = '0;
                    end
                    n_res_st  = ST_OK;
                    n_res_new = 1'b0;
                    n_res_ma  = '0;
                    n_res_mb  = '0;
                    n_res_mc  = '0;
                    n_state   = (s_axis_tuser[0] == REQ_FACE) ? S_FACE_A : S_VCHK;
                end
            end
            S_VCHK: begin
                n_found = 1'b0;
                n_iss   = '0;
                if (r_vc >= CNT_W'(MAX_VERTICES)) begin
                    n_res_st = ST_FULL;
                    n_state  = S_RESULT;
                end else if (r_kc == '0) begin
                    n_state = S_COMMIT;
                end else begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (cmp_tag.vld && (cmp_match || cmp_tag.last)) begin
                    // first match in kept order wins; later reads in flight are dropped
                    kill    = 1'b1;
                    n_found = cmp_match;
                    n_hit   = cmp_tag.idx;
                    n_state = S_COMMIT;
                end else if (r_iss < r_kc) begin
                    kept_re       = 1'b1;
                    n_rd_tag.vld  = 1'b1;
                    n_rd_tag.last = (r_iss == r_kc - CNT_W'(1));
                    n_rd_tag.idx  = IDX_W'(r_iss);
                    n_iss         = r_iss + CNT_W'(1);
                end
            end
            S_COMMIT: begin
                if (!r_found) begin
                    kept_we = 1'b1;
                    n_kc    = r_kc + CNT_W'(1);
                end
                remap_we  = 1'b1;
                n_vc      = r_vc + CNT_W'(1);
                n_res_new = !r_found;
                n_res_ma  = FIELD_W'(commit_idx);
                n_state   = S_RESULT;
            end
            S_FACE_A: begin
                remap_re = 1'b1;
                n_state  = S_FACE_B;
            end
            S_FACE_B: begin
                remap_re = 1'b1;
                n_res_ma = prev_map;
                if (!prev_ok) begin
                    n_res_st = ST_UNLOADED;
                end
                n_state = S_FACE_C;
            end
            S_FACE_C: begin
                remap_re = 1'b1;
                n_res_mb = prev_map;
                if (!prev_ok) begin
                    n_res_st = ST_UNLOADED;
                end
                n_state = S_FACE_W;
            end
            S_FACE_W: begin
                n_res_mc = prev_map;
                if (!prev_ok) begin
                    n_res_st = ST_UNLOADED;
                end
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_vld || m_axis_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_data = {(OUT_DATA_W - 3 * FIELD_W)'(0), r_res_mc, r_res_mb, r_res_ma};
                    n_out_user = {r_res_new, r_res_st};
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol     <= '0;
            r_vc      <= '0;
            r_kc      <= '0;
            r_rd_tag  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
            r_vc      <= n_vc;
            r_kc      <= n_kc;
            r_rd_tag  <= n_rd_tag;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_iss      <= n_iss;
        r_item     <= n_item;
        r_found    <= n_found;
        r_hit      <= n_hit;
        r_res_st   <= n_res_st;
        r_res_new  <= n_res_new;
        r_res_ma   <= n_res_ma;
        r_res_mb   <= n_res_mb;
        r_res_mc   <= n_res_mc;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
    end

endmodule

### rtl/core/vwir_checker.sv
// vwir_checker: port-level assertions for the vertex weld / index remap core, bound to the top
// depends on vwir_pkg for status codes and port widths
module vwir_checker
    import vwir_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser
);

    // a result transaction stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped before it was taken");

    // no result comes out of reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser[1:0] == ST_OK || m_axis_tuser[1:0] == ST_FULL ||
                           m_axis_tuser[1:0] == ST_UNLOADED))
        else $error("unknown status code");

    // a newly kept vertex is a clean vertex result
    a_new_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[2] |->
            m_axis_tuser[1:0] == ST_OK && m_axis_tdata[29:10] == '0)
        else $error("new vertex result with face fields or error status");

    // full table leaves every mapped field at zero
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1:0] == ST_FULL |->
            m_axis_tdata[29:0] == '0 && !m_axis_tuser[2])
        else $error("full-table result carries data");

endmodule

bind vertex_weld_index_remap_core vwir_checker u_vwir_checker (.*);
